// ----- sv/ntfl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfl_pkg - shared types and constants for the nearest time fix lookup
// Widths, item modes, register indexes, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ntfl_pkg;

    localparam int MAX_FIXES = 1024;
    localparam int ADDR_W    = (MAX_FIXES > 1) ? $clog2(MAX_FIXES) : 1;
    localparam int CNT_W     = $clog2(MAX_FIXES + 1);

    localparam int TIME_W    = 48;
    localparam int LAT_W     = 31;
    localparam int LON_W     = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CONF_W    = 7;
    localparam int MODE_W    = 2;
    localparam int FIX_W     = TIME_W + LAT_W + LON_W;

    localparam logic [CFG_W-1:0] MAX_GAP_RST   = 24'd86400;
    localparam logic [CFG_W-1:0] TIER_HIGH_RST = 24'd300;
    localparam logic [CFG_W-1:0] TIER_MID_RST  = 24'd3600;
    localparam logic [CFG_W-1:0] TIER_LOW_RST  = 24'd21600;

    localparam logic [CONF_W-1:0] CONF_HIGH = 7'd95;
    localparam logic [CONF_W-1:0] CONF_MID  = 7'd75;
    localparam logic [CONF_W-1:0] CONF_LOW  = 7'd40;
    localparam logic [CONF_W-1:0] CONF_POOR = 7'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_GAP   = 2'd0,
        CFG_TIER_HIGH = 2'd1,
        CFG_TIER_MID  = 2'd2,
        CFG_TIER_LOW  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic rd_last;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/nearest_time_fix_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_time_fix_lookup - nearest-in-time location fix search
// Clear, append and empty-store query beats skip the scan; a new beat is taken only once
// the last result is loaded. Query beats over N stored fixes scan the store through the
// single RAM read port, which reads one stored fix per cycle, then drain the pipeline.
// Reset (aresetn, synchronous): store empty, settings to their defaults; stored
// entries keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module nearest_time_fix_lookup (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ntfl_pkg::MODE_W-1:0]            s_mode,
    input  logic signed [ntfl_pkg::TIME_W-1:0]     s_item_time,
    input  logic signed [ntfl_pkg::LAT_W-1:0]      s_lat_e7,
    input  logic signed [ntfl_pkg::LON_W-1:0]      s_lon_e7,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_found,
    output logic signed [ntfl_pkg::LAT_W-1:0]      m_best_lat_e7,
    output logic signed [ntfl_pkg::LON_W-1:0]      m_best_lon_e7,
    output logic [ntfl_pkg::CONF_W-1:0]            m_confidence,
    output logic                                   m_status,
    input  logic                                   cfg_we,
    input  logic [ntfl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ntfl_pkg::CFG_W-1:0]             cfg_wdata
);
    import ntfl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ntfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .status  (status),
        .cmd     (cmd)
    );

    ntfl_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_mode        (s_mode),
        .s_item_time   (s_item_time),
        .s_lat_e7      (s_lat_e7),
        .s_lon_e7      (s_lon_e7),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_best_lat_e7 (m_best_lat_e7),
        .m_best_lon_e7 (m_best_lon_e7),
        .m_confidence  (m_confidence),
        .m_status      (m_status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

endmodule

// ----- sv/ntfl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfl_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ntfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ntfl_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfl_ctrl - sequencer for the fix lookup
// Takes one beat at a time, steps the store scan for queries, waits for the
// compare pipeline to empty and hands the result to the output register.
// ----------------------------------------------------------------------------
module ntfl_ctrl (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ntfl_pkg::MODE_W-1:0]            s_mode,
    input  ntfl_pkg::dp_status_t                   status,
    output ntfl_pkg::ctrl_cmd_t                    cmd
);
    import ntfl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == MODE_QUERY && !status.count_zero) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (status.rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_RESULT: begin
                cmd.load_out = status.out_free;
            end
            default: begin
            end
        endcase
    end

    // once the compare pipeline is empty the drain must move on to the result hand-off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && !status.pipe_busy) |=> state_reg == ST_RESULT)
        else $error("drain did not move to result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg != ST_IDLE)
        else $error("accepted beat left no work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> state_reg == ST_IDLE)
        else $error("result loaded without returning to idle");

endmodule

// ----- sv/ntfl_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfl_dpath - fix store, gap pipeline and result register
// Holds the fix RAM and count, the settings, a three stage read / gap /
// compare pipeline for the scan, and the registered result beat.
// ----------------------------------------------------------------------------
module ntfl_dpath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ntfl_pkg::ctrl_cmd_t                    cmd,
    output ntfl_pkg::dp_status_t                   status,
    input  logic [ntfl_pkg::MODE_W-1:0]            s_mode,
    input  logic signed [ntfl_pkg::TIME_W-1:0]     s_item_time,
    input  logic signed [ntfl_pkg::LAT_W-1:0]      s_lat_e7,
    input  logic signed [ntfl_pkg::LON_W-1:0]      s_lon_e7,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_found,
    output logic signed [ntfl_pkg::LAT_W-1:0]      m_best_lat_e7,
    output logic signed [ntfl_pkg::LON_W-1:0]      m_best_lon_e7,
    output logic [ntfl_pkg::CONF_W-1:0]            m_confidence,
    output logic                                   m_status,
    input  logic                                   cfg_we,
    input  logic [ntfl_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ntfl_pkg::CFG_W-1:0]             cfg_wdata
);
    import ntfl_pkg::*;

    // settings
    logic [CFG_W-1:0] max_gap_reg;
    logic [CFG_W-1:0] tier_high_reg;
    logic [CFG_W-1:0] tier_mid_reg;
    logic [CFG_W-1:0] tier_low_reg;

    // item and store bookkeeping
    logic [MODE_W-1:0] mode_reg;
    logic [TIME_W-1:0] q_time_reg;
    logic              drop_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] rd_idx_reg;

    // scan pipeline
    logic              v1_reg;
    logic              v2_reg;
    logic [TIME_W-1:0] gap_reg;
    logic [LAT_W-1:0]  lat2_reg;
    logic [LON_W-1:0]  lon2_reg;
    logic              best_valid_reg;
    logic [TIME_W-1:0] near_gap_reg;
    logic [LAT_W-1:0]  best_lat_reg;
    logic [LON_W-1:0]  best_lon_reg;

    // result register
    logic              m_valid_reg;
    logic              found_reg;
    logic [LAT_W-1:0]  lat_out_reg;
    logic [LON_W-1:0]  lon_out_reg;
    logic [CONF_W-1:0] conf_out_reg;
    logic              status_out_reg;

    logic              full;
    logic              do_write;
    logic [FIX_W-1:0]  wr_fix;
    logic [FIX_W-1:0]  rd_fix;
    logic [TIME_W-1:0] rd_time;
    logic [TIME_W:0]   diff_qf;
    logic [TIME_W:0]   diff_fq;
    logic [TIME_W-1:0] gap;
    logic              better;
    logic              found;
    logic [CONF_W-1:0] conf;

    assign full     = (count_reg == CNT_W'(MAX_FIXES));
    assign do_write = cmd.accept && (s_mode == MODE_APPEND) && !full;
    assign wr_fix   = {s_item_time, s_lat_e7, s_lon_e7};

    ntfl_ram #(
        .WIDTH (FIX_W),
        .DEPTH (MAX_FIXES)
    ) u_fix_ram (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (wr_fix),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg),
        .rdata (rd_fix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg   <= MAX_GAP_RST;
            tier_high_reg <= TIER_HIGH_RST;
            tier_mid_reg  <= TIER_MID_RST;
            tier_low_reg  <= TIER_LOW_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_GAP:   max_gap_reg   <= cfg_wdata;
                CFG_TIER_HIGH: tier_high_reg <= cfg_wdata;
                CFG_TIER_MID:  tier_mid_reg  <= cfg_wdata;
                CFG_TIER_LOW:  tier_low_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.accept && s_mode == MODE_CLEAR) begin
            count_reg <= '0;
        end else if (do_write) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg   <= s_mode;
            q_time_reg <= s_item_time;
            drop_reg   <= (s_mode == MODE_APPEND) && full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
        end else if (cmd.accept) begin
            rd_idx_reg <= '0;
        end else if (cmd.rd_en) begin
            rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
        end
    end

    // gap as both differences in parallel, the non-negative one chosen
    assign rd_time = rd_fix[FIX_W-1 -: TIME_W];
    assign diff_qf = {q_time_reg[TIME_W-1], q_time_reg} - {rd_time[TIME_W-1], rd_time};
    assign diff_fq = {rd_time[TIME_W-1], rd_time} - {q_time_reg[TIME_W-1], q_time_reg};
    assign gap     = diff_qf[TIME_W] ? diff_fq[TIME_W-1:0] : diff_qf[TIME_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            gap_reg  <= gap;
            lat2_reg <= rd_fix[LON_W +: LAT_W];
            lon2_reg <= rd_fix[LON_W-1:0];
        end
    end

    // strict less-than keeps the first stored fix on a tie
    assign better = !best_valid_reg || (gap_reg < near_gap_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
        end else if (cmd.accept) begin
            best_valid_reg <= 1'b0;
        end else if (v2_reg) begin
            best_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && better) begin
            near_gap_reg <= gap_reg;
            best_lat_reg <= lat2_reg;
            best_lon_reg <= lon2_reg;
        end
    end

    assign found = (mode_reg == MODE_QUERY) && best_valid_reg
                   && (near_gap_reg <= TIME_W'(max_gap_reg));

    always_comb begin
        if (near_gap_reg <= TIME_W'(tier_high_reg)) begin
            conf = CONF_HIGH;
        end else if (near_gap_reg <= TIME_W'(tier_mid_reg)) begin
            conf = CONF_MID;
        end else if (near_gap_reg <= TIME_W'(tier_low_reg)) begin
            conf = CONF_LOW;
        end else begin
            conf = CONF_POOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            found_reg      <= found;
            lat_out_reg    <= found ? best_lat_reg : '0;
            lon_out_reg    <= found ? best_lon_reg : '0;
            conf_out_reg   <= found ? conf : '0;
            status_out_reg <= drop_reg;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.rd_last    = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign status.pipe_busy  = v1_reg || v2_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_best_lat_e7 = lat_out_reg;
    assign m_best_lon_e7 = lon_out_reg;
    assign m_confidence  = conf_out_reg;
    assign m_status      = status_out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (count_reg != '0) && (CNT_W'(rd_idx_reg) < count_reg))
        else $error("scan read beyond the filled part of the store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FIXES))
        else $error("fix count above store depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !v1_reg && !v2_reg)
        else $error("result loaded with compare pipeline still busy");

endmodule
